>>> rtl/core/rrbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbm_pkg
// Types and constants for the ROM/RAM bank mapper.
// ----------------------------------------------------------------------------
package rrbm_pkg;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_BANKS      = 4;

    localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int ROM_OFS_W = $clog2(ROM_BANK_BYTES);
    localparam int RAM_OFS_W = $clog2(RAM_BANK_BYTES);

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int ROM_AW    = 21;
    localparam int BANK_W    = 7;

    localparam logic       FUNC_READ  = 1'b0;
    localparam logic       FUNC_WRITE = 1'b1;

    localparam logic [ADDR_W-1:0] ENABLE_LAST = 16'h1FFF;
    localparam logic [ADDR_W-1:0] LOBANK_LAST = 16'h3FFF;
    localparam logic [ADDR_W-1:0] HIBANK_LAST = 16'h5FFF;
    localparam logic [ADDR_W-1:0] MODE_LAST   = 16'h7FFF;
    localparam logic [ADDR_W-1:0] RAM_FIRST   = 16'hA000;
    localparam logic [ADDR_W-1:0] RAM_LAST    = 16'hBFFF;

    localparam logic [3:0]        ENABLE_KEY  = 4'hA;
    localparam logic [DATA_W-1:0] MODE_ROM    = 8'h00;
    localparam logic [DATA_W-1:0] MODE_RAM    = 8'h01;
    localparam logic [BANK_W-1:0] BANK_RESET  = 7'h01;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic              rom_read;
        logic [ROM_AW-1:0] rom_address;
        logic [DATA_W-1:0] read_data;
        logic              mode_error;
    } t_rsp;

endpackage
`default_nettype wire

>>> rtl/core/rom_ram_bank_mapper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Registers: accept -> r_s1 (r_ram_q for a RAM read) -> r_out -> o_valid.
// Throughput: one request per cycle unless r_out is stalled with r_s1 full;
// the single-port RAM is read or written at most once per accepted request.
// Reset: clears pipeline valids, RAM enable, banking mode and bank (to 1).
// RAM contents are not cleared and are undefined until written.
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_unit
// Cartridge bank controller: control register writes, ROM address mapping
// and banked internal RAM.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire rrbm_pkg::t_req i_req,
    output logic               o_valid,
    input  wire                i_ready,
    output rrbm_pkg::t_rsp     o_rsp
);

    logic [rrbm_pkg::DATA_W-1:0] r_ram [rrbm_pkg::RAM_DEPTH];
    logic [rrbm_pkg::DATA_W-1:0] r_ram_q;

    logic [rrbm_pkg::BANK_W-1:0] r_bank, n_bank;
    logic                        r_mode, n_mode;
    logic                        r_en, n_en;

    logic                        r_s1_v;
    rrbm_pkg::t_rsp              r_s1, n_s1;
    logic                        r_s1_ram, n_s1_ram;

    logic                        r_out_v;
    rrbm_pkg::t_rsp              r_out, n_out;

    logic                        accept, out_free, s1_move;
    logic                        in_ram, ram_wr, ram_rd;
    logic [1:0]                  ram_bank;
    logic [rrbm_pkg::RAM_AW-1:0] ram_idx;
    logic [rrbm_pkg::BANK_W-1:0] rom_bank;
    logic [4:0]                  lo_bank;

    assign out_free = !r_out_v || i_ready;
    assign s1_move  = r_s1_v && out_free;
    assign o_ready  = !r_s1_v || out_free;
    assign accept   = i_valid && o_ready;

    assign in_ram   = (i_req.address >= rrbm_pkg::RAM_FIRST)
                   && (i_req.address <= rrbm_pkg::RAM_LAST);
    assign ram_bank = r_mode ? r_bank[6:5] : 2'd0;
    assign ram_idx  = rrbm_pkg::RAM_AW'(
                          (int'(ram_bank) % rrbm_pkg::RAM_BANKS) * rrbm_pkg::RAM_BANK_BYTES
                        + int'(i_req.address[rrbm_pkg::RAM_OFS_W-1:0]));
    assign ram_wr   = accept && in_ram && r_en && (i_req.func == rrbm_pkg::FUNC_WRITE);
    assign ram_rd   = accept && in_ram && r_en && (i_req.func == rrbm_pkg::FUNC_READ);
    assign rom_bank = r_mode ? {2'b00, r_bank[4:0]} : r_bank;
    assign lo_bank  = (i_req.write_data[4:0] == 5'd0) ? 5'd1 : i_req.write_data[4:0];

    always_comb begin
        n_bank   = r_bank;
        n_mode   = r_mode;
        n_en     = r_en;
        n_s1     = '0;
        n_s1_ram = 1'b0;
        if (i_req.func == rrbm_pkg::FUNC_READ) begin
            if (i_req.address <= rrbm_pkg::LOBANK_LAST) begin
                n_s1.rom_read    = 1'b1;
                n_s1.rom_address = rrbm_pkg::ROM_AW'(i_req.address);
            end else if (i_req.address <= rrbm_pkg::MODE_LAST) begin
                n_s1.rom_read    = 1'b1;
                n_s1.rom_address = {rom_bank, i_req.address[rrbm_pkg::ROM_OFS_W-1:0]};
            end else if (in_ram && r_en) begin
                n_s1_ram = 1'b1;
            end
        end else if (!in_ram) begin
            if (i_req.address <= rrbm_pkg::ENABLE_LAST) begin
                n_en = (i_req.write_data[3:0] == rrbm_pkg::ENABLE_KEY);
            end else if (i_req.address <= rrbm_pkg::LOBANK_LAST) begin
                n_bank = {r_bank[6:5], lo_bank};
            end else if (i_req.address <= rrbm_pkg::HIBANK_LAST) begin
                n_bank = {i_req.write_data[1:0], r_bank[4:0]};
            end else if (i_req.address <= rrbm_pkg::MODE_LAST) begin
                if (i_req.write_data == rrbm_pkg::MODE_ROM) begin
                    n_mode = 1'b0;
                end else if (i_req.write_data == rrbm_pkg::MODE_RAM) begin
                    n_mode = 1'b1;
                end else begin
                    n_s1.mode_error = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out           = r_s1;
        n_out.read_data = r_s1_ram ? r_ram_q : '0;
    end

    // bank RAM: at most one access per accepted request
    always_ff @(posedge i_clk) begin
        if (ram_wr) begin
            r_ram[ram_idx] <= i_req.write_data;
        end
        if (ram_rd) begin
            r_ram_q <= r_ram[ram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= rrbm_pkg::BANK_RESET;
            r_mode  <= 1'b0;
            r_en    <= 1'b0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (accept) begin
                r_bank <= n_bank;
                r_mode <= n_mode;
                r_en   <= n_en;
            end
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1     <= n_s1;
            r_s1_ram <= n_s1_ram;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

endmodule
`default_nettype wire

>>> rtl/core/rrbm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbm_checker
// Port-level checks for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module rrbm_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_valid,
    input wire                 i_ready,
    input wire rrbm_pkg::t_rsp o_rsp
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)))
        else $error("response dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid right after reset");

    a_rom_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.rom_read) |-> (!o_rsp.mode_error && o_rsp.read_data == '0))
        else $error("ROM read carries RAM data or mode error");

    a_addr_only_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.rom_read) |-> (o_rsp.rom_address == '0))
        else $error("ROM address on a non-ROM response");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.mode_error) |-> (o_rsp.read_data == '0))
        else $error("mode error with read data");

endmodule

bind rom_ram_bank_mapper_unit rrbm_checker u_rrbm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus reads and writes into the bank mapper with random gaps and
// response stalls. Each response is checked against an in-bench model of the
// bank registers, banking mode, RAM enable and RAM contents.
// ----------------------------------------------------------------------------
module testbench;
    import rrbm_pkg::*;

    localparam int RANDOM_ACCESSES = 1050;
    localparam int QUIET_FROM      = 900;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              mode;
        logic              enabled;
    } t_map_regs;

    typedef struct {
        t_req rq;
        bit   drain;
        bit   calm;
    } t_bus_access;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    t_req req = '0;
    logic rsp_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    t_rsp o_rsp;

    t_bus_access access_q [$];
    t_rsp        rsp_due [$];

    t_map_regs         map_regs = '{bank: BANK_RESET, mode: 1'b0, enabled: 1'b0};
    logic [DATA_W-1:0] ram_image [RAM_DEPTH];
    t_map_regs         gen_regs = '{bank: BANK_RESET, mode: 1'b0, enabled: 1'b0};
    bit                slot_written [RAM_DEPTH];
    int                ofs_pool [16];
    bit                gen_calm = 1'b0;
    bit                gen_drain = 1'b0;

    int  gap_left = 0;
    int  stall_left = 0;
    int  send_pct = 0;
    int  stall_pct = 0;
    bit  quiet = 1'b0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_fail = 0;
    int  n_ram_reads = 0;
    int  n_mode_err = 0;
    int  cycles = 0;

    rom_ram_bank_mapper_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_ready (o_ready),
        .i_req   (req),
        .o_valid (o_valid),
        .i_ready (rsp_ready),
        .o_rsp   (o_rsp)
    );

    always #5 clk = ~clk;

    function automatic int ram_slot(t_map_regs r, logic [ADDR_W-1:0] a);
        int rb;
        rb = r.mode ? int'(r.bank[BANK_W-1:BANK_W-2]) : 0;
        rb = rb % RAM_BANKS;
        return rb * RAM_BANK_BYTES + (int'(a - RAM_FIRST) & (RAM_BANK_BYTES - 1));
    endfunction

    function automatic t_map_regs step_regs(t_map_regs r, t_req q, output logic bad_mode);
        t_map_regs n;
        n = r;
        bad_mode = 1'b0;
        if (q.func == FUNC_WRITE) begin
            if (q.address <= ENABLE_LAST) begin
                n.enabled = (q.write_data[3:0] == ENABLE_KEY);
            end else if (q.address <= LOBANK_LAST) begin
                n.bank[4:0] = (q.write_data[4:0] == 5'd0) ? 5'd1 : q.write_data[4:0];
            end else if (q.address <= HIBANK_LAST) begin
                n.bank[BANK_W-1:BANK_W-2] = q.write_data[1:0];
            end else if (q.address <= MODE_LAST) begin
                if (q.write_data == MODE_ROM) begin
                    n.mode = 1'b0;
                end else if (q.write_data == MODE_RAM) begin
                    n.mode = 1'b1;
                end else begin
                    bad_mode = 1'b1;
                end
            end
        end
        return n;
    endfunction

    function automatic t_rsp mapper_predict(t_req q);
        t_rsp              p;
        logic              bad;
        logic              in_ram;
        int                slot;
        logic [BANK_W-1:0] rom_bank;
        p = '0;
        in_ram = (q.address >= RAM_FIRST) && (q.address <= RAM_LAST);
        slot = ram_slot(map_regs, q.address);
        rom_bank = map_regs.mode ? {2'b00, map_regs.bank[4:0]} : map_regs.bank;
        if (q.func == FUNC_READ) begin
            if (q.address <= LOBANK_LAST) begin
                p.rom_read = 1'b1;
                p.rom_address = ROM_AW'(q.address);
            end else if (q.address <= MODE_LAST) begin
                p.rom_read = 1'b1;
                p.rom_address = {rom_bank, q.address[ROM_OFS_W-1:0]};
            end else if (in_ram && map_regs.enabled) begin
                p.read_data = ram_image[slot];
                n_ram_reads++;
            end
        end else if (in_ram && map_regs.enabled) begin
            ram_image[slot] = q.write_data;
        end
        map_regs = step_regs(map_regs, q, bad);
        p.mode_error = bad;
        if (bad) n_mode_err++;
        return p;
    endfunction

    function automatic int pct_pick();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 12;
            default: return 35;
        endcase
    endfunction

    task automatic push_req(logic f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        t_bus_access acc;
        logic        bad;
        acc.rq.func = f;
        acc.rq.address = a;
        acc.rq.write_data = d;
        acc.drain = gen_drain;
        acc.calm = gen_calm;
        gen_drain = 1'b0;
        if (f == FUNC_WRITE && a >= RAM_FIRST && a <= RAM_LAST && gen_regs.enabled)
            slot_written[ram_slot(gen_regs, a)] = 1'b1;
        gen_regs = step_regs(gen_regs, acc.rq, bad);
        access_q.push_back(acc);
    endtask

    // reads of unwritten bytes turn into writes while RAM is enabled
    task automatic ram_access(bit wr);
        logic [ADDR_W-1:0] a;
        a = RAM_FIRST + ADDR_W'(ofs_pool[$urandom_range(0, 15)]);
        if (!wr && gen_regs.enabled && !slot_written[ram_slot(gen_regs, a)])
            wr = 1'b1;
        push_req(wr ? FUNC_WRITE : FUNC_READ, a, DATA_W'($urandom));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (req_valid && o_ready) begin
                rsp_due.push_back(mapper_predict(req));
                n_sent++;
                if (n_sent % 100 == 0) send_pct = pct_pick();
            end
            if (!req_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    req_valid <= 1'b0;
                end else if (access_q.size() == 0 ||
                             (access_q[0].drain && rsp_due.size() != 0)) begin
                    req_valid <= 1'b0;
                end else if (!access_q[0].calm && $urandom_range(0, 99) < send_pct) begin
                    gap_left <= $urandom_range(0, 10);
                    req_valid <= 1'b0;
                end else begin
                    req_valid <= 1'b1;
                    req <= access_q[0].rq;
                    quiet <= access_q[0].calm;
                    access_q.pop_front();
                end
            end
        end
    end

    always @(posedge clk) begin
        t_rsp want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && rsp_ready) begin
                if (rsp_due.size() == 0) begin
                    $error("response with none outstanding: %h", o_rsp);
                    n_fail++;
                end else begin
                    want = rsp_due.pop_front();
                    n_checked++;
                    if (n_checked % 100 == 0) stall_pct = pct_pick();
                    if (o_rsp.rom_read !== want.rom_read) begin
                        $error("rom_read: expected %0h, got %0h", want.rom_read, o_rsp.rom_read);
                        n_fail++;
                    end
                    if (o_rsp.rom_address !== want.rom_address) begin
                        $error("rom_address: expected %0h, got %0h",
                               want.rom_address, o_rsp.rom_address);
                        n_fail++;
                    end
                    if (o_rsp.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, o_rsp.read_data);
                        n_fail++;
                    end
                    if (o_rsp.mode_error !== want.mode_error) begin
                        $error("mode_error: expected %0h, got %0h",
                               want.mode_error, o_rsp.mode_error);
                        n_fail++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                rsp_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                stall_left <= $urandom_range(0, 10);
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL rom_ram_bank_mapper_unit");
            $finish;
        end
    end

    initial begin
        int sel;
        ofs_pool[0] = 0;
        ofs_pool[1] = RAM_BANK_BYTES - 1;
        for (int k = 2; k < 16; k++) ofs_pool[k] = $urandom_range(0, RAM_BANK_BYTES - 1);

        // fixed and banked ROM bounds, unmapped space, RAM disabled, then enabled
        push_req(FUNC_READ, 16'h0000, 8'hFF);
        push_req(FUNC_READ, LOBANK_LAST, 8'h00);
        push_req(FUNC_READ, 16'h4000, 8'h00);
        push_req(FUNC_READ, MODE_LAST, 8'h00);
        push_req(FUNC_READ, 16'h8000, 8'h00);
        push_req(FUNC_READ, 16'hFFFF, 8'h00);
        push_req(FUNC_READ, RAM_FIRST, 8'h00);
        push_req(FUNC_WRITE, RAM_LAST, 8'hFF);
        push_req(FUNC_WRITE, 16'h1000, 8'hFA);
        push_req(FUNC_WRITE, RAM_FIRST, 8'h5A);
        push_req(FUNC_READ, RAM_FIRST, 8'h00);
        // bank zero maps to one, then max bank
        push_req(FUNC_WRITE, 16'h2000, 8'h00);
        push_req(FUNC_READ, 16'h4000, 8'h00);
        push_req(FUNC_WRITE, LOBANK_LAST, 8'hFF);
        push_req(FUNC_WRITE, HIBANK_LAST, 8'hFF);
        push_req(FUNC_READ, MODE_LAST, 8'h00);
        push_req(FUNC_WRITE, 16'h6000, MODE_RAM);
        push_req(FUNC_READ, MODE_LAST, 8'h00);
        push_req(FUNC_WRITE, RAM_LAST, 8'hA5);
        push_req(FUNC_READ, RAM_LAST, 8'h00);
        // bad mode values, back to ROM mode, RAM disabled again, unmapped writes
        push_req(FUNC_WRITE, MODE_LAST, 8'h02);
        push_req(FUNC_WRITE, 16'h6000, 8'hFF);
        push_req(FUNC_WRITE, 16'h6000, MODE_ROM);
        push_req(FUNC_READ, RAM_FIRST, 8'h00);
        push_req(FUNC_WRITE, ENABLE_LAST, 8'hF0);
        push_req(FUNC_READ, RAM_LAST, 8'h00);
        push_req(FUNC_WRITE, 16'h8000, 8'hFF);
        push_req(FUNC_WRITE, 16'hFFFF, 8'h00);

        for (int i = 0; i < RANDOM_ACCESSES; i++) begin
            gen_calm = (i >= QUIET_FROM);
            gen_drain = (i == 0 || i == RANDOM_ACCESSES / 2);
            sel = $urandom_range(0, 99);
            if (sel < 33) begin
                push_req(FUNC_READ, ADDR_W'($urandom_range(0, MODE_LAST)), DATA_W'($urandom));
            end else if (sel < 63) begin
                ram_access($urandom_range(0, 2) == 0);
            end else if (sel < 71) begin
                push_req(FUNC_WRITE, ADDR_W'($urandom_range(0, ENABLE_LAST)),
                         ($urandom_range(0, 4) == 0) ? DATA_W'($urandom)
                                                     : {4'($urandom), ENABLE_KEY});
            end else if (sel < 78) begin
                push_req(FUNC_WRITE, ADDR_W'($urandom_range(ENABLE_LAST + 1, LOBANK_LAST)),
                         DATA_W'($urandom));
            end else if (sel < 85) begin
                push_req(FUNC_WRITE, ADDR_W'($urandom_range(LOBANK_LAST + 1, HIBANK_LAST)),
                         DATA_W'($urandom));
            end else if (sel < 92) begin
                push_req(FUNC_WRITE, ADDR_W'($urandom_range(HIBANK_LAST + 1, MODE_LAST)),
                         ($urandom_range(0, 4) == 0) ? DATA_W'($urandom)
                         : ($urandom_range(0, 1) == 0 ? MODE_ROM : MODE_RAM));
            end else begin
                push_req(1'($urandom),
                         ($urandom_range(0, 1) == 0)
                             ? ADDR_W'($urandom_range(MODE_LAST + 1, RAM_FIRST - 1))
                             : ADDR_W'($urandom_range(RAM_LAST + 1, 16'hFFFF)),
                         DATA_W'($urandom));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (access_q.size() != 0 || req_valid || rsp_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests, %0d responses checked", n_sent, n_checked);
        $display("%0d enabled RAM reads, %0d rejected mode writes", n_ram_reads, n_mode_err);
        if (n_fail == 0) begin
            $display("PASS rom_ram_bank_mapper_unit");
        end else begin
            $display("FAIL rom_ram_bank_mapper_unit");
        end
        $finish;
    end

endmodule
